// ===== sv/mmce_pkg.sv =====
`timescale 1ns / 1ps
package mmce_pkg;
    localparam int unsigned NUM_W   = 50;  // dividend width
    localparam int unsigned DEN_W   = 33;  // divisor width (2 * span)
    localparam int unsigned Q_W     = 16;  // widest code
    localparam int unsigned DIV_LAT = 16;  // one quotient bit per stage
    localparam int unsigned PRE_LAT = 2;
    localparam int unsigned LANES   = 5;

    localparam logic [0:0] OP_MOTION = 1'b0;
    localparam logic [0:0] OP_ENABLE = 1'b1;

    localparam logic [63:0] ENABLE_FRAME = 64'hFFFF_FFFF_FFFF_FFFC;

    localparam logic [2:0] REG_POSITION  = 3'd0;
    localparam logic [2:0] REG_VELOCITY  = 3'd1;
    localparam logic [2:0] REG_STIFFNESS = 3'd2;
    localparam logic [2:0] REG_DAMPING   = 3'd3;
    localparam logic [2:0] REG_TORQUE    = 3'd4;

    localparam logic [30:0] POSITION_RST  = 31'd819200;
    localparam logic [30:0] VELOCITY_RST  = 31'd1966080;
    localparam logic [30:0] STIFFNESS_RST = 31'd32768000;
    localparam logic [30:0] DAMPING_RST   = 31'd327680;
    localparam logic [30:0] TORQUE_RST    = 31'd655360;

    // sym: range is +/- limit, else 0..limit; wide: 16-bit code, else 12-bit
    typedef struct packed {
        logic sym;
        logic wide;
    } lane_mode_t;

    typedef struct packed {
        logic        op;
        logic [1:0]  bus;
        logic [10:0] can_id;
    } frame_meta_t;
endpackage

// ===== sv/mmce_prep.sv =====
`timescale 1ns / 1ps
// Clamp, then build dividend (off*(2^n-1)*2 + span) and divisor (2*span).
module mmce_prep (
    input  logic                              clk,
    input  mmce_pkg::lane_mode_t              mode,
    input  logic signed [31:0]                x,
    input  logic [30:0]                       limit,
    output logic [mmce_pkg::NUM_W-1:0]        num,
    output logic [mmce_pkg::DEN_W-1:0]        den,
    output logic                              zero
);
    logic signed [33:0] xs;
    logic signed [33:0] ls;
    logic [31:0]        off_next;
    logic [31:0]        span_next;
    logic [31:0]        off_reg;
    logic [31:0]        span_reg;
    logic               zero1_reg;
    logic               wide_reg;
    logic [49:0]        prod;
    logic [mmce_pkg::NUM_W-1:0] num_reg;
    logic [mmce_pkg::DEN_W-1:0] den_reg;
    logic               zero2_reg;

    always_comb
    begin
        xs = 34'(x);
        ls = $signed({3'b000, limit});
        if (mode.sym)
        begin
            span_next = {limit, 1'b0};
            if (xs < -ls)
                off_next = '0;
            else if (xs > ls)
                off_next = {limit, 1'b0};
            else
                off_next = 32'(xs + ls);
        end
        else
        begin
            span_next = {1'b0, limit};
            if (xs < 34'sd0)
                off_next = '0;
            else if (xs > ls)
                off_next = {1'b0, limit};
            else
                off_next = 32'(xs);
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg   <= off_next;
        span_reg  <= span_next;
        zero1_reg <= (limit == '0);
        wide_reg  <= mode.wide;
    end

    always_comb
    begin
        if (wide_reg)
            prod = ({18'd0, off_reg} << 16) - {18'd0, off_reg};
        else
            prod = ({18'd0, off_reg} << 12) - {18'd0, off_reg};
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= {prod[48:0], 1'b0} + {18'd0, span_reg};
        den_reg   <= {span_reg, 1'b0};
        zero2_reg <= zero1_reg;
    end

    assign num  = num_reg;
    assign den  = den_reg;
    assign zero = zero2_reg;
endmodule

// ===== sv/mmce_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per registered stage, MSB first.
module mmce_div (
    input  logic                          clk,
    input  logic [mmce_pkg::NUM_W-1:0]    num,
    input  logic [mmce_pkg::DEN_W-1:0]    den,
    input  logic                          zero,
    output logic [mmce_pkg::Q_W-1:0]      quo
);
    logic [mmce_pkg::NUM_W-1:0] rem_reg  [0:mmce_pkg::DIV_LAT];
    logic [mmce_pkg::DEN_W-1:0] den_reg  [0:mmce_pkg::DIV_LAT];
    logic [mmce_pkg::Q_W-1:0]   q_reg    [0:mmce_pkg::DIV_LAT];
    logic                       zero_reg [0:mmce_pkg::DIV_LAT];

    always_comb
    begin
        rem_reg[0]  = num;
        den_reg[0]  = den;
        q_reg[0]    = '0;
        zero_reg[0] = zero;
    end

    for (genvar s = 0; s < mmce_pkg::DIV_LAT; s++)
    begin : g_step
        localparam int unsigned BIT = mmce_pkg::DIV_LAT - 1 - s;
        logic [mmce_pkg::NUM_W-1:0] dsh;
        logic                       ge;

        assign dsh = mmce_pkg::NUM_W'(den_reg[s]) << BIT;
        assign ge  = (rem_reg[s] >= dsh);

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= ge ? rem_reg[s] - dsh : rem_reg[s];
            den_reg[s+1]  <= den_reg[s];
            zero_reg[s+1] <= zero_reg[s];
            q_reg[s+1]    <= q_reg[s] | (ge ? (mmce_pkg::Q_W'(1) << BIT) : '0);
        end
    end

    assign quo = zero_reg[mmce_pkg::DIV_LAT] ? '0 : q_reg[mmce_pkg::DIV_LAT];
endmodule

// ===== sv/mit_motor_command_frame_encoder.sv =====
`timescale 1ns / 1ps
// Motor command frame encoder. Pulse start with a command word; busy is always low, so a
// new word is taken every cycle. Op 0 clamps the five Q16.16 values to the configured
// limits and rounds each into its 16- or 12-bit code; op 1 sends the fixed enable frame.
// Each word with a nonzero can_id gives one frame on out_strobe after passing through 2
// clamp/scale stages, 16 divider stages and 1 output register; the divider stages are the
// bit-per-stage restoring dividers, one per value. A zero can_id gives no frame.
// Results are shown for one cycle and cannot be held off. Limits are written over APB
// at 4*index and should only change while no words are in flight.
module mit_motor_command_frame_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [1:0]         bus_select,
    input  logic [10:0]        can_id,
    input  logic signed [31:0] target_position,
    input  logic signed [31:0] target_velocity,
    input  logic signed [31:0] stiffness_gain,
    input  logic signed [31:0] damping_gain,
    input  logic signed [31:0] feedforward_torque,
    output logic               out_strobe,
    output logic [1:0]         out_bus,
    output logic [10:0]        out_can_id,
    output logic [63:0]        payload
);
    localparam int unsigned LAT = mmce_pkg::PRE_LAT + mmce_pkg::DIV_LAT;

    logic [30:0] lim_reg [0:mmce_pkg::LANES-1];
    logic        wr;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg[0] <= mmce_pkg::POSITION_RST;
            lim_reg[1] <= mmce_pkg::VELOCITY_RST;
            lim_reg[2] <= mmce_pkg::STIFFNESS_RST;
            lim_reg[3] <= mmce_pkg::DAMPING_RST;
            lim_reg[4] <= mmce_pkg::TORQUE_RST;
        end
        else if (wr)
        begin
            case (ridx)
                mmce_pkg::REG_POSITION:  lim_reg[0] <= pwdata[30:0];
                mmce_pkg::REG_VELOCITY:  lim_reg[1] <= pwdata[30:0];
                mmce_pkg::REG_STIFFNESS: lim_reg[2] <= pwdata[30:0];
                mmce_pkg::REG_DAMPING:   lim_reg[3] <= pwdata[30:0];
                mmce_pkg::REG_TORQUE:    lim_reg[4] <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            mmce_pkg::REG_POSITION:  prdata = {1'b0, lim_reg[0]};
            mmce_pkg::REG_VELOCITY:  prdata = {1'b0, lim_reg[1]};
            mmce_pkg::REG_STIFFNESS: prdata = {1'b0, lim_reg[2]};
            mmce_pkg::REG_DAMPING:   prdata = {1'b0, lim_reg[3]};
            mmce_pkg::REG_TORQUE:    prdata = {1'b0, lim_reg[4]};
            default:                 prdata = '0;
        endcase
    end

    // five lanes: position, velocity, stiffness, damping, torque
    logic signed [31:0]            lane_x    [0:mmce_pkg::LANES-1];
    mmce_pkg::lane_mode_t          lane_mode [0:mmce_pkg::LANES-1];
    logic [mmce_pkg::NUM_W-1:0]    lane_num  [0:mmce_pkg::LANES-1];
    logic [mmce_pkg::DEN_W-1:0]    lane_den  [0:mmce_pkg::LANES-1];
    logic                          lane_zero [0:mmce_pkg::LANES-1];
    logic [mmce_pkg::Q_W-1:0]      lane_q    [0:mmce_pkg::LANES-1];

    assign lane_x[0] = target_position;
    assign lane_x[1] = target_velocity;
    assign lane_x[2] = stiffness_gain;
    assign lane_x[3] = damping_gain;
    assign lane_x[4] = feedforward_torque;
    assign lane_mode[0] = '{sym: 1'b1, wide: 1'b1};
    assign lane_mode[1] = '{sym: 1'b1, wide: 1'b0};
    assign lane_mode[2] = '{sym: 1'b0, wide: 1'b0};
    assign lane_mode[3] = '{sym: 1'b0, wide: 1'b0};
    assign lane_mode[4] = '{sym: 1'b1, wide: 1'b0};

    for (genvar i = 0; i < mmce_pkg::LANES; i++)
    begin : g_lane
        mmce_prep u_prep (
            .clk   (clk),
            .mode  (lane_mode[i]),
            .x     (lane_x[i]),
            .limit (lim_reg[i]),
            .num   (lane_num[i]),
            .den   (lane_den[i]),
            .zero  (lane_zero[i])
        );
        mmce_div u_div (
            .clk  (clk),
            .num  (lane_num[i]),
            .den  (lane_den[i]),
            .zero (lane_zero[i]),
            .quo  (lane_q[i])
        );
    end

    // valid and frame header ride alongside the lanes
    logic                  vld_reg  [0:LAT-1];
    mmce_pkg::frame_meta_t meta_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && (can_id != 11'd0);
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= '{op: op, bus: bus_select, can_id: can_id};
        for (int k = 1; k < LAT; k++)
            meta_reg[k] <= meta_reg[k-1];
    end

    mmce_pkg::frame_meta_t tail;
    logic [63:0]           payload_next;
    logic                  strobe_reg;
    logic [1:0]            bus_reg;
    logic [10:0]           id_reg;
    logic [63:0]           payload_reg;

    assign tail = meta_reg[LAT-1];

    always_comb
    begin
        if (tail.op == mmce_pkg::OP_ENABLE)
            payload_next = mmce_pkg::ENABLE_FRAME;
        else
            payload_next = {lane_q[0], lane_q[1][11:0], lane_q[2][11:0],
                            lane_q[3][11:0], lane_q[4][11:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        bus_reg     <= tail.bus;
        id_reg      <= tail.can_id;
        payload_reg <= payload_next;
    end

    assign out_strobe = strobe_reg;
    assign out_bus    = bus_reg;
    assign out_can_id = id_reg;
    assign payload    = payload_reg;

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> out_can_id != 11'd0)
        else $error("frame with zero id");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> $past(start && (can_id != 11'd0), LAT + 1))
        else $error("frame without matching command");

    a_bus_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> out_bus == $past(bus_select, LAT + 1))
        else $error("bus mismatch");

    a_enable_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && $past(op, LAT + 1) == mmce_pkg::OP_ENABLE)
            |-> payload == mmce_pkg::ENABLE_FRAME)
        else $error("bad enable frame");
endmodule
